### hdl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and codes for the go-back-N sender: the input and result
// transactions, command, result-kind and timer-action codes.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int SEQ_W     = 8;
    localparam int DATA_W    = 32;
    localparam int WIN_W     = 4;
    localparam int CNT_W     = 4;
    // most packets resent in one timeout burst
    localparam int RESULT_CAP = 8;

    localparam logic [1:0] CMD_SEND    = 2'd0;
    localparam logic [1:0] CMD_ACK     = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    localparam logic [2:0] KIND_SENT     = 3'd0;
    localparam logic [2:0] KIND_REFUSED  = 3'd1;
    localparam logic [2:0] KIND_ACK_OK   = 3'd2;
    localparam logic [2:0] KIND_ACK_BAD  = 3'd3;
    localparam logic [2:0] KIND_ACK_OUT  = 3'd4;
    localparam logic [2:0] KIND_IDLE_TO  = 3'd5;

    localparam logic [1:0] TMR_NONE    = 2'd0;
    localparam logic [1:0] TMR_START   = 2'd1;
    localparam logic [1:0] TMR_STOP    = 2'd2;
    localparam logic [1:0] TMR_RESTART = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [DATA_W-1:0] payload;
        logic [SEQ_W-1:0]  ack_num;
        logic              ack_ok;
    } t_in;

    typedef struct packed {
        logic [2:0]        kind;
        logic [SEQ_W-1:0]  seq;
        logic [DATA_W-1:0] data_out;
        logic [1:0]        timer_action;
        logic [SEQ_W-1:0]  timer_seq;
        logic              window_full;
        logic              last;
    } t_out;

endpackage

### hdl/gbn_store.sv
// ----------------------------------------------------------------------------
// gbn_store
// Packet ring buffer: one write port, one read port with registered data.
// The read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module gbn_store #(
    parameter int BUFFER_DEPTH = 8
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [$clog2(BUFFER_DEPTH)-1:0]   i_wr_addr,
    input  logic [gbn_pkg::DATA_W-1:0]        i_wr_data,
    input  logic                              i_rd_en,
    input  logic [$clog2(BUFFER_DEPTH)-1:0]   i_rd_addr,
    output logic [gbn_pkg::DATA_W-1:0]        o_rd_data
);

    logic [gbn_pkg::DATA_W-1:0] r_mem [BUFFER_DEPTH];
    logic [gbn_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/go_back_n_sender_top.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_top
// Go-back-N sender: window control, ring buffer of sent packets and the
// timeout resend burst.
// ----------------------------------------------------------------------------
//  channel   signals                          direction  payload
//  input     i_valid / o_stall / i_data       in         gbn_pkg::t_in
//  result    o_valid / i_stall / o_data       out        gbn_pkg::t_out
//  config    i_cfg_valid / o_cfg_ready        in         i_cfg_data (window size)
//
//  Send and ack commands each give one registered result; unknown commands
//  are dropped. A timeout with n packets outstanding is taken in ST_IDLE,
//  the first read of the buffer is done in ST_READ, then ST_EMIT gives one
//  resent packet per cycle from its single read port while not stalled.
//  A timeout with nothing outstanding gives a single result.
//  Reset is synchronous; the buffer is not cleared.
//  o_stall is high during a burst and while a stalled result is held.
// ----------------------------------------------------------------------------
module go_back_n_sender_top #(
    parameter int BUFFER_DEPTH = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  gbn_pkg::t_in                i_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output gbn_pkg::t_out               o_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gbn_pkg::WIN_W-1:0]   i_cfg_data
);

    localparam int SW   = $clog2(BUFFER_DEPTH);
    localparam int CAP  = (BUFFER_DEPTH < gbn_pkg::RESULT_CAP) ? BUFFER_DEPTH
                                                                : gbn_pkg::RESULT_CAP;
    localparam int SUMW = ((SW > gbn_pkg::CNT_W) ? SW : gbn_pkg::CNT_W) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } t_state;

    t_state                          r_state;
    gbn_pkg::t_out                   r_out;
    logic                            r_out_valid;
    logic [gbn_pkg::WIN_W-1:0]       r_win;
    logic [gbn_pkg::SEQ_W-1:0]       r_base;
    logic [gbn_pkg::SEQ_W-1:0]       r_next;
    logic                            r_waiting;
    logic [SW-1:0]                   r_base_slot;
    logic [SW-1:0]                   r_wr_slot;
    logic [SW-1:0]                   r_rd_slot;
    logic [gbn_pkg::CNT_W-1:0]       r_cnt;
    logic [gbn_pkg::CNT_W-1:0]       r_n;

    gbn_pkg::t_out                   n_out;
    logic                            n_out_valid;
    logic                            w_out_free;
    logic                            w_accept;
    logic [gbn_pkg::WIN_W-1:0]       w_eff_win;
    logic [gbn_pkg::SEQ_W-1:0]       w_outst;
    logic [gbn_pkg::SEQ_W-1:0]       w_outst_inc;
    logic [gbn_pkg::SEQ_W-1:0]       w_ack_off;
    logic [gbn_pkg::SEQ_W-1:0]       w_new_base;
    logic [gbn_pkg::CNT_W-1:0]       w_step;
    logic [SUMW-1:0]                 w_slot_sum;
    logic [SW-1:0]                   w_new_base_slot;
    logic [SW-1:0]                   n_wr_slot;
    logic [SW-1:0]                   n_rd_slot;
    logic                            w_burst_last;
    logic                            w_load_burst;
    logic                            w_wr_en;
    logic                            w_rd_en;
    logic [SW-1:0]                   w_rd_addr;
    logic [gbn_pkg::DATA_W-1:0]      w_rd_data;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = !((r_state == ST_IDLE) && w_out_free);
    assign w_accept   = i_valid && !o_stall;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;
    assign o_cfg_ready = 1'b1;

    // clamp the window to [1, min(depth, burst cap)]
    always_comb begin
        if (r_win == '0) begin
            w_eff_win = gbn_pkg::WIN_W'(1);
        end else if (r_win > gbn_pkg::WIN_W'(CAP)) begin
            w_eff_win = gbn_pkg::WIN_W'(CAP);
        end else begin
            w_eff_win = r_win;
        end
    end

    assign w_outst     = r_next - r_base;
    assign w_outst_inc = w_outst + 8'd1;
    assign w_ack_off   = i_data.ack_num - r_base;
    assign w_new_base  = i_data.ack_num + 8'd1;

    // offset + 1 never exceeds the window cap, so one subtract wraps the slot
    assign w_step     = gbn_pkg::CNT_W'(w_ack_off) + gbn_pkg::CNT_W'(1);
    assign w_slot_sum = SUMW'(r_base_slot) + SUMW'(w_step);
    assign w_new_base_slot = (w_slot_sum >= SUMW'(BUFFER_DEPTH))
                           ? SW'(w_slot_sum - SUMW'(BUFFER_DEPTH))
                           : SW'(w_slot_sum);

    assign n_wr_slot = (r_wr_slot == SW'(BUFFER_DEPTH - 1)) ? '0 : r_wr_slot + SW'(1);
    assign n_rd_slot = (r_rd_slot == SW'(BUFFER_DEPTH - 1)) ? '0 : r_rd_slot + SW'(1);

    assign w_burst_last = (r_cnt + gbn_pkg::CNT_W'(1)) == r_n;
    assign w_load_burst = (r_state == ST_EMIT) && w_out_free;

    assign w_wr_en = w_accept && (i_data.cmd == gbn_pkg::CMD_SEND)
                   && !r_waiting && (w_outst < 8'(w_eff_win));

    // fetch the next resend slot as the current one is loaded
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_rd_slot;
        if (r_state == ST_READ) begin
            w_rd_en = 1'b1;
        end else if (w_load_burst && !w_burst_last) begin
            w_rd_en   = 1'b1;
            w_rd_addr = n_rd_slot;
        end
    end

    gbn_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_wr_slot),
        .i_wr_data (i_data.payload),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // result register next value: hold while stalled, load on a transaction
    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        if (w_accept) begin
            n_out.seq          = '0;
            n_out.data_out     = '0;
            n_out.timer_action = gbn_pkg::TMR_NONE;
            n_out.timer_seq    = r_base;
            n_out.window_full  = r_waiting;
            n_out.last         = 1'b1;
            unique case (i_data.cmd)
                gbn_pkg::CMD_SEND: begin
                    n_out_valid = 1'b1;
                    if (w_wr_en) begin
                        n_out.kind     = gbn_pkg::KIND_SENT;
                        n_out.seq      = r_next;
                        n_out.data_out = i_data.payload;
                        if (r_base == r_next) begin
                            n_out.timer_action = gbn_pkg::TMR_START;
                        end
                        if (w_outst_inc >= 8'(w_eff_win)) begin
                            n_out.window_full = 1'b1;
                        end
                    end else begin
                        n_out.kind        = gbn_pkg::KIND_REFUSED;
                        n_out.window_full = 1'b1;
                    end
                end
                gbn_pkg::CMD_ACK: begin
                    n_out_valid = 1'b1;
                    if (!i_data.ack_ok) begin
                        n_out.kind = gbn_pkg::KIND_ACK_BAD;
                    end else if (w_ack_off >= w_outst) begin
                        n_out.kind = gbn_pkg::KIND_ACK_OUT;
                    end else begin
                        n_out.kind        = gbn_pkg::KIND_ACK_OK;
                        n_out.window_full = 1'b0;
                        if (w_new_base == r_next) begin
                            n_out.timer_action = gbn_pkg::TMR_STOP;
                        end else begin
                            n_out.timer_action = gbn_pkg::TMR_RESTART;
                            n_out.timer_seq    = w_new_base;
                        end
                    end
                end
                gbn_pkg::CMD_TIMEOUT: begin
                    if (w_outst == '0) begin
                        n_out_valid = 1'b1;
                        n_out.kind  = gbn_pkg::KIND_IDLE_TO;
                    end
                end
                default: begin
                    // unknown command: drop
                end
            endcase
        end else if (w_load_burst) begin
            n_out_valid        = 1'b1;
            n_out.kind         = gbn_pkg::KIND_SENT;
            n_out.seq          = r_base + 8'(r_cnt);
            n_out.data_out     = w_rd_data;
            n_out.timer_action = (r_cnt == '0) ? gbn_pkg::TMR_RESTART
                                               : gbn_pkg::TMR_NONE;
            n_out.timer_seq    = r_base;
            n_out.window_full  = r_waiting;
            n_out.last         = w_burst_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out       <= '0;
            r_out_valid <= 1'b0;
            r_win       <= gbn_pkg::WIN_W'(4);
            r_base      <= '0;
            r_next      <= '0;
            r_waiting   <= 1'b0;
            r_base_slot <= '0;
            r_wr_slot   <= '0;
            r_rd_slot   <= '0;
            r_cnt       <= '0;
            r_n         <= '0;
        end else begin
            r_out       <= n_out;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_win <= i_cfg_data;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        unique case (i_data.cmd)
                            gbn_pkg::CMD_SEND: begin
                                if (w_wr_en) begin
                                    r_next    <= r_next + 8'd1;
                                    r_wr_slot <= n_wr_slot;
                                    if (w_outst_inc >= 8'(w_eff_win)) begin
                                        r_waiting <= 1'b1;
                                    end
                                end else begin
                                    r_waiting <= 1'b1;
                                end
                            end
                            gbn_pkg::CMD_ACK: begin
                                if (i_data.ack_ok && (w_ack_off < w_outst)) begin
                                    r_waiting   <= 1'b0;
                                    r_base      <= w_new_base;
                                    r_base_slot <= w_new_base_slot;
                                end
                            end
                            gbn_pkg::CMD_TIMEOUT: begin
                                if (w_outst != '0) begin
                                    r_rd_slot <= r_base_slot;
                                    r_cnt     <= '0;
                                    r_n       <= gbn_pkg::CNT_W'(w_outst);
                                    r_state   <= ST_READ;
                                end
                            end
                            default: begin
                                // unknown command: drop
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        if (w_burst_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_cnt     <= r_cnt + gbn_pkg::CNT_W'(1);
                            r_rd_slot <= n_rd_slot;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // outstanding packets never exceed the buffer or the burst cap
    a_outst_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_outst <= 8'(CAP))
        else $error("outstanding count beyond window cap");

    // burst index stays inside the resend count
    a_burst_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_cnt < r_n))
        else $error("burst index past resend count");

    // only a resent packet can be a non-final result
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.last) |-> (o_data.kind == gbn_pkg::KIND_SENT))
        else $error("non-final result of a single-result command");

    // an outstanding timeout starts a burst on the next cycle
    a_burst_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_data.cmd == gbn_pkg::CMD_TIMEOUT) && (w_outst != '0))
        |=> (r_state == ST_READ))
        else $error("timeout did not start a resend burst");

endmodule
